// File: rtl/core/jtag_command_sequencer_macros.svh
// assertion macros shared by the checker
`ifndef JTAG_COMMAND_SEQUENCER_MACROS_SVH
`define JTAG_COMMAND_SEQUENCER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define JCS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jcs check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define JCS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jcs check failed");

`endif

// File: rtl/core/jcs_pkg.sv
package jcs_pkg;

    // command word
    typedef struct packed {
        logic        kind;
        logic [2:0]  op;
        logic [31:0] payload;
        logic [17:0] clock_count;
        logic        tdo;
    } jcs_in_t;

    // result word
    typedef struct packed {
        logic        tms;
        logic        tdi;
        logic        tck_pulse;
        logic        busy_res;
        logic        done_res;
        logic        accepted;
        logic [31:0] read_value;
    } jcs_out_t;

    // item kinds
    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // command codes
    localparam logic [2:0] OP_RESET_IDLE  = 3'd0;
    localparam logic [2:0] OP_LOAD_INSTR  = 3'd1;
    localparam logic [2:0] OP_WRITE_DATA  = 3'd2;
    localparam logic [2:0] OP_READ_DATA   = 3'd3;
    localparam logic [2:0] OP_IDLE_CLOCKS = 3'd4;

    // command in progress
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_RESET,
        ACT_IR,
        ACT_DW,
        ACT_DR,
        ACT_IDLE
    } jcs_act_t;

    // sequence lengths in ticks
    localparam int RESET_TMS_TCKS = 8;   // TMS high to reach Test-Logic-Reset
    localparam int RTI_TCKS       = 8;   // TMS low in Run-Test/Idle
    localparam int IR_LEAD_TCKS   = 4;   // idle -> Shift-IR
    localparam int DR_LEAD_TCKS   = 3;   // idle -> Shift-DR
    localparam int TAIL_TCKS      = 1 + RTI_TCKS;  // update, then idle

endpackage

// File: rtl/core/jtag_command_sequencer.sv
// a result word is registered and valid in the cycle after its command or tick word is taken
// throughput: one word per cycle while cmd_stall is low; the TAP walk state advances once per tick
// cmd_stall rises only while the result register is full and rsp_stall holds it
// reset (rst_n low, async): no command active, counter and shift registers cleared,
// tms and tdi held low, no result pending
module jtag_command_sequencer
    import jcs_pkg::*;
#(
    parameter int IR_BITS    = 8,
    parameter int DATA_BITS  = 32,
    parameter int COUNT_BITS = 18
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  jcs_in_t  cmd_item,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output jcs_out_t rsp_item
);

    // handshake glue: a word is taken whenever the result slot can accept it
    logic     slot_open;
    logic     take;
    jcs_out_t step_res;

    assign take      = cmd_valid && slot_open;
    assign cmd_stall = !slot_open;

    // tap walk: command decode, phase counter, shift registers, pin levels
    jcs_seq #(
        .IR_BITS    (IR_BITS),
        .DATA_BITS  (DATA_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (cmd_item),
        .res   (step_res)
    );

    // result register between the walk logic and the consumer
    jcs_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .res       (step_res),
        .rsp_stall (rsp_stall),
        .open      (slot_open),
        .rsp_valid (rsp_valid),
        .rsp_item  (rsp_item)
    );

endmodule

// File: rtl/core/jcs_seq.sv
module jcs_seq
    import jcs_pkg::*;
#(
    parameter int IR_BITS    = 8,
    parameter int DATA_BITS  = 32,
    parameter int COUNT_BITS = 18
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     take,
    input  jcs_in_t  item,
    output jcs_out_t res
);

    localparam int RESET_LEN = RESET_TMS_TCKS + RTI_TCKS;
    localparam int IR_LEN    = IR_LEAD_TCKS + IR_BITS + TAIL_TCKS;
    localparam int DR_LEN    = DR_LEAD_TCKS + DATA_BITS + TAIL_TCKS;
    localparam int LEN_MAX   = (IR_LEN > DR_LEN) ? IR_LEN : DR_LEN;
    localparam int LEN_W     = $clog2(LEN_MAX + 1);
    localparam int PW        = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;

    localparam logic [PW-1:0] C_RESET_HALF = PW'(RESET_TMS_TCKS);
    localparam logic [PW-1:0] C_RESET_LEN  = PW'(RESET_LEN);
    localparam logic [PW-1:0] C_IR_SEL     = PW'(2);
    localparam logic [PW-1:0] C_IR_LEAD    = PW'(IR_LEAD_TCKS);
    localparam logic [PW-1:0] C_IR_LAST    = PW'(IR_LEAD_TCKS + IR_BITS - 1);
    localparam logic [PW-1:0] C_IR_END     = PW'(IR_LEAD_TCKS + IR_BITS);
    localparam logic [PW-1:0] C_IR_LEN     = PW'(IR_LEN);
    localparam logic [PW-1:0] C_DR_LEAD    = PW'(DR_LEAD_TCKS);
    localparam logic [PW-1:0] C_DR_LAST    = PW'(DR_LEAD_TCKS + DATA_BITS - 1);
    localparam logic [PW-1:0] C_DR_END     = PW'(DR_LEAD_TCKS + DATA_BITS);
    localparam logic [PW-1:0] C_DR_LEN     = PW'(DR_LEN);

    jcs_act_t        act_reg, act_next;
    logic [PW-1:0]   cnt_reg, cnt_next;
    logic [31:0]     so_reg, so_next;
    logic [31:0]     si_reg, si_next;
    logic            tdi_reg, tdi_next;
    logic            tms_reg, tms_next;

    logic [COUNT_BITS-1:0] count_src;
    logic [PW-1:0]         count_ext;
    logic [PW-1:0]         cnt_inc;
    logic [PW-1:0]         cnt_dec;
    logic [PW-1:0]         len;
    logic                  pulse;
    logic                  done;
    logic                  acc;

    assign count_src = COUNT_BITS'(item.clock_count);
    assign count_ext = PW'(count_src);
    assign cnt_inc   = cnt_reg + PW'(1);
    assign cnt_dec   = cnt_reg - PW'(1);

    always_comb
    begin
        act_next = act_reg;
        cnt_next = cnt_reg;
        so_next  = so_reg;
        si_next  = si_reg;
        tdi_next = tdi_reg;
        tms_next = tms_reg;
        pulse    = 1'b0;
        done     = 1'b0;
        acc      = 1'b0;
        len      = C_RESET_LEN;
        if (take)
        begin
            if (item.kind == KIND_CMD)
            begin
                if (act_reg == ACT_NONE && item.op <= OP_IDLE_CLOCKS)
                begin
                    acc      = 1'b1;
                    so_next  = item.payload;
                    cnt_next = '0;
                    case (item.op)
                        OP_RESET_IDLE:  act_next = ACT_RESET;
                        OP_LOAD_INSTR:  act_next = ACT_IR;
                        OP_WRITE_DATA:  act_next = ACT_DW;
                        OP_READ_DATA:
                        begin
                            act_next = ACT_DR;
                            si_next  = '0;
                        end
                        default:
                        begin
                            cnt_next = count_ext;
                            if (count_ext == '0)
                                done = 1'b1;
                            else
                                act_next = ACT_IDLE;
                        end
                    endcase
                end
            end
            else if (act_reg != ACT_NONE)
            begin
                pulse = 1'b1;
                case (act_reg)
                    ACT_IDLE:
                    begin
                        cnt_next = cnt_dec;
                        done     = (cnt_dec == '0);
                    end
                    ACT_RESET:
                    begin
                        len      = C_RESET_LEN;
                        tms_next = (cnt_reg < C_RESET_HALF);
                        cnt_next = cnt_inc;
                        done     = (cnt_inc == len);
                    end
                    ACT_IR:
                    begin
                        len = C_IR_LEN;
                        if (cnt_reg < C_IR_LEAD)
                            tms_next = (cnt_reg < C_IR_SEL);
                        else if (cnt_reg < C_IR_END)
                        begin
                            tms_next = (cnt_reg == C_IR_LAST);
                            tdi_next = so_reg[0];
                            so_next  = so_reg >> 1;
                        end
                        else
                            tms_next = (cnt_reg == C_IR_END);
                        cnt_next = cnt_inc;
                        done     = (cnt_inc == len);
                    end
                    default:
                    begin
                        // write and read share the DR walk
                        len = C_DR_LEN;
                        if (cnt_reg < C_DR_LEAD)
                            tms_next = (cnt_reg == '0);
                        else if (cnt_reg < C_DR_END)
                        begin
                            tms_next = (cnt_reg == C_DR_LAST);
                            if (act_reg == ACT_DW)
                            begin
                                tdi_next = so_reg[0];
                                so_next  = so_reg >> 1;
                            end
                            else
                                si_next = {si_reg[30:0], item.tdo};
                        end
                        else
                            tms_next = (cnt_reg == C_DR_END);
                        cnt_next = cnt_inc;
                        done     = (cnt_inc == len);
                    end
                endcase
                if (done)
                begin
                    act_next = ACT_NONE;
                    cnt_next = '0;
                end
            end
        end
    end

    always_comb
    begin
        res.tms        = tms_next;
        res.tdi        = tdi_next;
        res.tck_pulse  = pulse;
        res.busy_res   = (act_next != ACT_NONE);
        res.done_res   = done;
        res.accepted   = acc;
        res.read_value = (done && act_reg == ACT_DR) ? si_next : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= ACT_NONE;
            cnt_reg <= '0;
            so_reg  <= '0;
            si_reg  <= '0;
            tdi_reg <= 1'b0;
            tms_reg <= 1'b0;
        end
        else
        begin
            act_reg <= act_next;
            cnt_reg <= cnt_next;
            so_reg  <= so_next;
            si_reg  <= si_next;
            tdi_reg <= tdi_next;
            tms_reg <= tms_next;
        end
    end

endmodule

// File: rtl/core/jcs_out_reg.sv
module jcs_out_reg
    import jcs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  jcs_out_t res,
    input  logic     rsp_stall,
    output logic     open,
    output logic     rsp_valid,
    output jcs_out_t rsp_item
);

    logic     valid_reg, valid_next;
    jcs_out_t item_reg;

    // slot is free when empty or being drained this cycle
    assign open = !valid_reg || !rsp_stall;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (rsp_stall)
            valid_next = valid_reg;
        else
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= res;
    end

    assign rsp_valid = valid_reg;
    assign rsp_item  = item_reg;

endmodule

// File: rtl/core/jcs_checker.sv
`include "jtag_command_sequencer_macros.svh"

module jcs_checker
    import jcs_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     cmd_valid,
    input logic     cmd_stall,
    input logic     rsp_valid,
    input logic     rsp_stall,
    input jcs_out_t rsp_item
);

    // a taken word shows up as a result word on the next cycle
    `JCS_ASSERT_NXT(a_take_shows, cmd_valid && !cmd_stall, rsp_valid)

    // a held result word stays put
    `JCS_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))

    // an ending word never reports more work
    `JCS_ASSERT_IMP(a_done_idle, rsp_valid && rsp_item.done_res, !rsp_item.busy_res)

    // ticks pulse, commands are acknowledged, never both
    `JCS_ASSERT_IMP(a_pulse_acc, rsp_valid && rsp_item.tck_pulse, !rsp_item.accepted)

    // read data shows only on an ending pulse
    `JCS_ASSERT_IMP(a_rval_done, rsp_valid && rsp_item.read_value != 32'd0, rsp_item.done_res && rsp_item.tck_pulse)

endmodule

bind jtag_command_sequencer jcs_checker u_jcs_checker (.*);

// File: tb/sv/jcs_check_pkg.sv
`timescale 1ns / 1ps

package jcs_check_pkg;
    import jcs_pkg::*;

    // shift lengths of the build under test
    localparam int IR_LEN    = 8;
    localparam int DATA_LEN  = 32;
    localparam int MAX_SHOWN = 10;

    class tap_pin_scoreboard;
        jcs_act_t    act;
        logic [17:0] phase;
        logic [31:0] bits_out;
        logic [31:0] bits_in;
        logic        tdi_lvl;
        logic        tms_lvl;
        jcs_out_t    pins_due[$];
        int          errors;
        int          checked;
        int          taken[5];
        int          refused;
        int          reads_done;

        function new();
            act        = ACT_NONE;
            phase      = '0;
            bits_out   = '0;
            bits_in    = '0;
            tdi_lvl    = 1'b0;
            tms_lvl    = 1'b0;
            errors     = 0;
            checked    = 0;
            refused    = 0;
            reads_done = 0;
            foreach (taken[k]) taken[k] = 0;
        endfunction

        function bit busy();
            return act != ACT_NONE;
        endfunction

        // works out the pins for one accepted word; returns 1 if it took or clocked
        function bit take_word(jcs_in_t w);
            jcs_out_t    r;
            logic [17:0] p;
            int unsigned len;
            int unsigned i;
            r   = '0;
            len = 0;
            if (w.kind == KIND_CMD) begin
                if (act == ACT_NONE && w.op <= OP_IDLE_CLOCKS) begin
                    r.accepted = 1'b1;
                    taken[w.op]++;
                    bits_out = w.payload;
                    phase    = '0;
                    if (w.op == OP_READ_DATA)
                        bits_in = '0;
                    if (w.op == OP_IDLE_CLOCKS && w.clock_count == '0) begin
                        r.done_res = 1'b1;
                    end
                    else begin
                        if (w.op == OP_IDLE_CLOCKS)
                            phase = w.clock_count;
                        act = jcs_act_t'(w.op + 3'd1);
                    end
                end
                else begin
                    refused++;
                end
            end
            else if (act != ACT_NONE) begin
                p           = phase;
                r.tck_pulse = 1'b1;
                case (act)
                    ACT_IDLE: begin
                        phase      = p - 18'd1;
                        r.done_res = (phase == '0);
                    end
                    ACT_RESET: begin
                        len     = RESET_TMS_TCKS + RTI_TCKS;
                        tms_lvl = (p < RESET_TMS_TCKS);
                    end
                    ACT_IR: begin
                        len = IR_LEAD_TCKS + IR_LEN + TAIL_TCKS;
                        if (p < IR_LEAD_TCKS) begin
                            tms_lvl = (p < 2);
                        end
                        else if (p < IR_LEAD_TCKS + IR_LEN) begin
                            i       = p - IR_LEAD_TCKS;
                            tms_lvl = (i == IR_LEN - 1);
                            tdi_lvl = bits_out[i];
                        end
                        else begin
                            tms_lvl = (p == IR_LEAD_TCKS + IR_LEN);
                        end
                    end
                    default: begin
                        len = DR_LEAD_TCKS + DATA_LEN + TAIL_TCKS;
                        if (p < DR_LEAD_TCKS) begin
                            tms_lvl = (p == 0);
                        end
                        else if (p < DR_LEAD_TCKS + DATA_LEN) begin
                            i       = p - DR_LEAD_TCKS;
                            tms_lvl = (i == DATA_LEN - 1);
                            if (act == ACT_DW)
                                tdi_lvl = bits_out[i];
                            else
                                bits_in = {bits_in[30:0], w.tdo};
                        end
                        else begin
                            tms_lvl = (p == DR_LEAD_TCKS + DATA_LEN);
                        end
                    end
                endcase
                if (act != ACT_IDLE) begin
                    phase = p + 18'd1;
                    if (phase >= len) begin
                        r.done_res = 1'b1;
                        if (act == ACT_DR) begin
                            r.read_value = bits_in;
                            reads_done++;
                        end
                    end
                end
                if (r.done_res) begin
                    act   = ACT_NONE;
                    phase = '0;
                end
            end
            r.tms      = tms_lvl;
            r.tdi      = tdi_lvl;
            r.busy_res = (act != ACT_NONE);
            pins_due.push_back(r);
            return r.accepted || r.tck_pulse;
        endfunction

        function void match_word(jcs_out_t got);
            jcs_out_t want;
            if (pins_due.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("result word with nothing pending: %p", got);
                return;
            end
            want = pins_due.pop_front();
            checked++;
            if (got.tms !== want.tms || got.tdi !== want.tdi ||
                got.tck_pulse !== want.tck_pulse || got.busy_res !== want.busy_res ||
                got.done_res !== want.done_res || got.accepted !== want.accepted ||
                got.read_value !== want.read_value) begin
                errors++;
                if (errors <= MAX_SHOWN) begin
                    $display("mismatch on result %0d at %0t", checked, $realtime);
                    $display("  expected %p", want);
                    $display("  actual   %p", got);
                end
            end
        endfunction
    endclass

endpackage

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import jcs_pkg::*;
    import jcs_check_pkg::*;

    // stop once this many words have taken a command or clocked the tap
    localparam int ITEM_TARGET = 1650;
    // receiver hold-off long enough to back the block up into its input
    localparam int HOLD_CYCLES = 300;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_stall;
    jcs_in_t  cmd_item  = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    jcs_out_t rsp_item;

    tap_pin_scoreboard sb = new();

    int unsigned burst_left = 0;
    int          useful     = 0;
    bit          hold_req   = 1'b0;

    jtag_command_sequencer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // hard stop in case the handshake hangs
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // sender: offers one word, bursts of random length separated by random gaps
    task automatic send_word(input jcs_in_t w);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            // mostly short bursts, now and then a long run with no gaps
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        cmd_valid <= 1'b1;
        cmd_item  <= w;
        // word is taken at the first edge where stall is low
        do
        begin
            @(posedge clk);
        end
        while (cmd_stall);
        if (sb.take_word(w))
            useful++;
    endtask

    // random word of the given kind, payload often at its extremes
    function automatic jcs_in_t rand_word(input logic kind);
        jcs_in_t w;
        int unsigned pick;
        pick          = $urandom_range(0, 9);
        w.kind        = kind;
        w.op          = 3'($urandom_range(0, 7));
        w.payload     = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
        w.clock_count = 18'($urandom);
        w.tdo         = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // idle pulse counts: mostly short, a few a bit longer
    function automatic logic [17:0] pick_count();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 14)
            return 18'($urandom_range(0, 20));
        else if (pick < 19)
            return 18'($urandom_range(21, 200));
        return 18'($urandom_range(201, 1500));
    endfunction

    task automatic issue(input logic kind, input logic [2:0] op, input logic [31:0] data,
                         input logic [17:0] count, input logic tdo);
        jcs_in_t w;
        w.kind        = kind;
        w.op          = op;
        w.payload     = data;
        w.clock_count = count;
        w.tdo         = tdo;
        send_word(w);
    endtask

    // clocks the tap until the command in progress finishes
    task automatic finish_command(input bit stray_cmds);
        while (sb.busy()) begin
            // a command now and then while busy must be refused
            if (stray_cmds && $urandom_range(0, 39) == 0)
                send_word(rand_word(KIND_CMD));
            send_word(rand_word(KIND_TICK));
        end
    endtask

    // well-formed sequence: command, then ticks until done
    task automatic run_command(input logic [2:0] op);
        jcs_in_t w;
        finish_command(1'b0);
        w    = rand_word(KIND_CMD);
        w.op = op;
        if (op == OP_IDLE_CLOCKS)
            w.clock_count = pick_count();
        send_word(w);
        finish_command(1'b1);
    endtask

    // noise: stray ticks, bad codes, commands cut short
    task automatic run_noise();
        jcs_in_t w;
        int unsigned n;
        case ($urandom_range(0, 2))
            0: send_word(rand_word(KIND_TICK));
            1: begin
                w    = rand_word(KIND_CMD);
                w.op = 3'($urandom_range(OP_IDLE_CLOCKS + 1, 7));
                send_word(w);
            end
            default: begin
                w = rand_word(KIND_CMD);
                if (w.op == OP_IDLE_CLOCKS)
                    w.clock_count = pick_count();
                send_word(w);
                n = $urandom_range(0, 12);
                repeat (n) send_word(rand_word(KIND_TICK));
            end
        endcase
    endtask

    // receiver: checks each taken result word and stalls on its own pattern
    initial
    begin : receiver
        int unsigned mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned tick_cnt;
        logic        stall;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        tick_cnt  = 0;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
                sb.match_word(rsp_item);
            tick_cnt++;
            if (hold_left != 0) begin
                hold_left--;
                stall = 1'b1;
            end
            else if (hold_req) begin
                // long hold-off, counted here while the sender keeps offering
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                stall     = 1'b1;
            end
            else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(32, 256);
                end
                mode_left--;
                case (mode)
                    0: stall = 1'b0;
                    1: stall = ($urandom_range(0, 3) == 0);
                    2: stall = (tick_cnt % 3 == 0);
                    default: stall = ($urandom_range(0, 3) != 0);
                endcase
            end
            rsp_stall <= stall;
        end
    end

    initial
    begin : stimulus
        logic [2:0] bad;
        int unsigned k;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: tick with nothing running
        issue(KIND_TICK, OP_RESET_IDLE, '0, '0, 1'b1);
        // directed: undefined codes are refused, payload, count and tdo at their top
        for (bad = OP_IDLE_CLOCKS + 3'd1; bad != OP_RESET_IDLE; bad++)
            issue(KIND_CMD, bad, '1, '1, 1'b1);
        // directed: zero idle count finishes on the command word
        issue(KIND_CMD, OP_IDLE_CLOCKS, '1, '0, 1'b0);
        // directed: short idle run with a command refused while busy
        issue(KIND_CMD, OP_IDLE_CLOCKS, '0, 18'd2, 1'b0);
        issue(KIND_CMD, OP_LOAD_INSTR, 32'h0000_00a5, '1, 1'b1);
        issue(KIND_TICK, OP_IDLE_CLOCKS, '1, '1, 1'b0);
        issue(KIND_TICK, OP_IDLE_CLOCKS, '0, '0, 1'b1);
        // directed: full reset-to-idle walk
        issue(KIND_CMD, OP_RESET_IDLE, '1, '0, 1'b0);
        k = 0;
        while (sb.busy()) begin
            issue(KIND_TICK, OP_RESET_IDLE, '0, '0, k[0]);
            k++;
        end

        // random part, starting with the long receiver hold-off
        hold_req = 1'b1;
        while (useful < ITEM_TARGET) begin
            if ($urandom_range(0, 9) < 8)
                run_command(3'($urandom_range(OP_RESET_IDLE, OP_IDLE_CLOCKS)));
            else
                run_noise();
        end

        cmd_valid <= 1'b0;
        // drain the pending results, then wait for stray words
        while (sb.pins_due.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        $display("run covered %0d words that took or clocked", useful);
        $display("  reset %0d, ir %0d, dw %0d, dr %0d, idle %0d",
                 sb.taken[OP_RESET_IDLE], sb.taken[OP_LOAD_INSTR],
                 sb.taken[OP_WRITE_DATA], sb.taken[OP_READ_DATA], sb.taken[OP_IDLE_CLOCKS]);
        $display("%0d commands refused, %0d reads finished, %0d results checked, %0d mismatches",
                 sb.refused, sb.reads_done, sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pins_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
